[design/jsu_pkg.sv]
package jsu_pkg;

  localparam int CharW = 21;
  localparam int HexW  = 16;
  localparam int ModeW = 3;

  // decode_mode codes; codes above HEX3 fall back to normal
  localparam logic [ModeW-1:0] MODE_NORMAL = 3'd0;
  localparam logic [ModeW-1:0] MODE_ESCAPE = 3'd1;
  localparam logic [ModeW-1:0] MODE_HEX0   = 3'd2;
  localparam logic [ModeW-1:0] MODE_HEX1   = 3'd3;
  localparam logic [ModeW-1:0] MODE_HEX2   = 3'd4;
  localparam logic [ModeW-1:0] MODE_HEX3   = 3'd5;

  localparam logic [CharW-1:0] CH_QUOTE  = 21'h00_0022;
  localparam logic [CharW-1:0] CH_BSLASH = 21'h00_005C;
  localparam logic [CharW-1:0] CH_SLASH  = 21'h00_002F;
  localparam logic [CharW-1:0] CH_B      = 21'h00_0062;
  localparam logic [CharW-1:0] CH_F      = 21'h00_0066;
  localparam logic [CharW-1:0] CH_N      = 21'h00_006E;
  localparam logic [CharW-1:0] CH_R      = 21'h00_0072;
  localparam logic [CharW-1:0] CH_T      = 21'h00_0074;
  localparam logic [CharW-1:0] CH_U      = 21'h00_0075;

  localparam logic [CharW-1:0] CTL_BS  = 21'h00_0008;
  localparam logic [CharW-1:0] CTL_FF  = 21'h00_000C;
  localparam logic [CharW-1:0] CTL_LF  = 21'h00_000A;
  localparam logic [CharW-1:0] CTL_CR  = 21'h00_000D;
  localparam logic [CharW-1:0] CTL_TAB = 21'h00_0009;

  typedef struct packed {
    logic             emit;
    logic             has_char;
    logic             eos;
    logic [CharW-1:0] ch;
  } dec_res_t;

endpackage

[design/jsu_decoder.sv]
module jsu_decoder (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     fire,
  input  logic [jsu_pkg::CharW-1:0] cp,
  input  logic                     last,
  output jsu_pkg::dec_res_t        res
);

  logic [jsu_pkg::ModeW-1:0] mode, mode_next;
  logic [jsu_pkg::HexW-1:0]  hex_value, hex_value_next;
  logic                      hex_stopped, hex_stopped_next;

  // {is_hex, digit}
  function automatic logic [4:0] hex_digit(input logic [jsu_pkg::CharW-1:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 21'h30 && c <= 21'h39) r = {1'b1, c[3:0]};
    else if ((c >= 21'h61 && c <= 21'h66) || (c >= 21'h41 && c <= 21'h46))
      r = {1'b1, 4'(c[3:0] + 4'd9)};
    return r;
  endfunction

  always_comb begin
    logic [4:0]              d;
    logic [jsu_pkg::HexW-1:0] hv;
    d                = hex_digit(cp);
    hv               = hex_value;
    mode_next        = jsu_pkg::MODE_NORMAL;
    hex_value_next   = hex_value;
    hex_stopped_next = hex_stopped;
    res.has_char     = 1'b0;
    res.ch           = '0;
    unique case (mode) inside
      jsu_pkg::MODE_ESCAPE: begin
        case (cp) inside
          jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH: begin
            res.ch = cp; res.has_char = 1'b1;
          end
          jsu_pkg::CH_B: begin res.ch = jsu_pkg::CTL_BS;  res.has_char = 1'b1; end
          jsu_pkg::CH_F: begin res.ch = jsu_pkg::CTL_FF;  res.has_char = 1'b1; end
          jsu_pkg::CH_N: begin res.ch = jsu_pkg::CTL_LF;  res.has_char = 1'b1; end
          jsu_pkg::CH_R: begin res.ch = jsu_pkg::CTL_CR;  res.has_char = 1'b1; end
          jsu_pkg::CH_T: begin res.ch = jsu_pkg::CTL_TAB; res.has_char = 1'b1; end
          jsu_pkg::CH_U: begin
            mode_next        = jsu_pkg::MODE_HEX0;
            hex_value_next   = '0;
            hex_stopped_next = 1'b0;
          end
          default: ;
        endcase
      end
      jsu_pkg::MODE_HEX0, jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2,
      jsu_pkg::MODE_HEX3: begin
        // digits stop at the first non-hex character, rest are swallowed
        if (!hex_stopped) begin
          if (!d[4]) hex_stopped_next = 1'b1;
          else       hv = {hex_value[jsu_pkg::HexW-5:0], d[3:0]};
        end
        hex_value_next = hv;
        if (mode == jsu_pkg::MODE_HEX3) begin
          res.ch           = jsu_pkg::CharW'(hv);
          res.has_char     = 1'b1;
          hex_value_next   = '0;
          hex_stopped_next = 1'b0;
        end else begin
          mode_next = 3'(mode + 3'd1);
        end
      end
      default: begin
        if (cp == jsu_pkg::CH_BSLASH) begin
          mode_next = jsu_pkg::MODE_ESCAPE;
        end else begin
          res.ch = cp; res.has_char = 1'b1;
        end
      end
    endcase
    if (last) begin
      mode_next        = jsu_pkg::MODE_NORMAL;
      hex_value_next   = '0;
      hex_stopped_next = 1'b0;
    end
    res.eos  = last;
    res.emit = res.has_char | last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= jsu_pkg::MODE_NORMAL;
      hex_value   <= '0;
      hex_stopped <= 1'b0;
    end else if (fire) begin
      mode        <= mode_next;
      hex_value   <= hex_value_next;
      hex_stopped <= hex_stopped_next;
    end
  end

endmodule

[design/json_string_unescape.sv]
// JSON string body unescape.
// Input channel (in_valid/in_ready): one code point of the string body per
// beat, without the enclosing quotes, with is_last on the final character.
// Output channel (out_valid/out_ready): out_char with has_char, and
// end_of_string on the beat caused by the last input character. A beat
// comes out only for a decoded character or for the last character; a
// backslash, an unknown escape letter and the four \u digits but the
// last one produce nothing. \u values come out as 16-bit codes.
// An accepted character goes through the input register, then the decode, then the result register.
// Throughput: one character per cycle while the receiver does not stall; the decode from the input register
// to the result register is a single pass of small compare/select logic.
// Reset clears both registers' valid flags and puts the decoder back in
// normal mode. When the receiver stalls, the result register holds its beat
// while the input register keeps taking characters that produce no output;
// in_ready drops only once a character that needs the output slot waits.
module json_string_unescape (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [jsu_pkg::CharW-1:0] code_point,
  input  logic                      is_last,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [jsu_pkg::CharW-1:0] out_char,
  output logic                      has_char,
  output logic                      end_of_string
);

  logic                      s1_valid;
  logic [jsu_pkg::CharW-1:0] s1_cp;
  logic                      s1_last;
  jsu_pkg::dec_res_t         res;
  logic                      out_free, s1_go;

  assign out_free = !out_valid || out_ready;
  assign s1_go    = s1_valid && (!res.emit || out_free);
  assign in_ready = !s1_valid || s1_go;

  jsu_decoder u_dec (
    .clk  (clk),
    .rst  (rst),
    .fire (s1_go),
    .cp   (s1_cp),
    .last (s1_last),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_cp   <= code_point;
      s1_last <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_go && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_go && res.emit) begin
      out_char      <= res.ch;
      has_char      <= res.has_char;
      end_of_string <= res.eos;
    end
  end

endmodule
